### src/cses_pkg.sv
`timescale 1ns / 1ps

package cses_pkg;

	localparam int DEFAULT_FRAME_BYTES = 8;
	localparam int BITS_PER_BYTE       = 8;
	localparam int DATA_W              = 64;
	localparam int START_W             = 6;
	localparam int LEN_W               = 7;
	localparam int COUNT_W             = 4;
	localparam int SCALE_W             = 32;
	localparam int VALUE_W             = 48;
	localparam int CFG_INDEX_W         = 3;
	localparam int RAW_W               = DATA_W + 1;
	localparam int HALF_W              = 32;
	localparam int PROD_W              = RAW_W;
	localparam int WIDE_W              = 98;

	localparam logic [START_W-1:0] START_RESET  = '0;
	localparam logic [LEN_W-1:0]   LEN_RESET    = LEN_W'(8);
	localparam logic [SCALE_W-1:0] SCALE_RESET  = SCALE_W'(65536);
	localparam logic [VALUE_W-1:0] OFFSET_RESET = '0;
	localparam logic [VALUE_W-1:0] LOWER_RESET  = {1'b1, {(VALUE_W-1){1'b0}}};
	localparam logic [VALUE_W-1:0] UPPER_RESET  = {1'b0, {(VALUE_W-1){1'b1}}};

	localparam logic BYTE_ORDER_INTEL    = 1'b0;
	localparam logic BYTE_ORDER_MOTOROLA = 1'b1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_START_BIT    = 3'd0,
		REG_BIT_LENGTH   = 3'd1,
		REG_BYTE_ORDER   = 3'd2,
		REG_IS_SIGNED    = 3'd3,
		REG_SCALE_FACTOR = 3'd4,
		REG_OFFSET_VALUE = 3'd5,
		REG_LOWER_LIMIT  = 3'd6,
		REG_UPPER_LIMIT  = 3'd7
	} cfg_reg_t;

	// Mirrors the bit order inside every byte, so that Motorola positions become linear.
	function automatic logic [DATA_W-1:0] mirror_bytes(input logic [DATA_W-1:0] d);
		logic [DATA_W-1:0] r;
		r = '0;
		for (int i = 0; i < DATA_W; i++) begin
			r[i] = d[(i & ~(BITS_PER_BYTE - 1)) + (BITS_PER_BYTE - 1) - (i & (BITS_PER_BYTE - 1))];
		end
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] reverse_word(input logic [DATA_W-1:0] d);
		logic [DATA_W-1:0] r;
		r = '0;
		for (int i = 0; i < DATA_W; i++) begin
			r[i] = d[DATA_W-1-i];
		end
		return r;
	endfunction

endpackage

### src/can_signal_extract_scale_core.sv
`timescale 1ns / 1ps

// A frame word passes through the stage registers s1 to s5 and then the output register.
// Throughput: one frame word per cycle while the output is not stalled.
// An output stall while out_valid is high freezes the whole pipeline and holds in_stall high.
// Reset clears the pipeline valid bits (not signal_valid) and loads every config register's default.
module can_signal_extract_scale_core
	import cses_pkg::*;
#(
	parameter int FRAME_BYTES = DEFAULT_FRAME_BYTES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write_en,
	input  logic [CFG_INDEX_W-1:0]        cfg_index,
	input  logic [VALUE_W-1:0]            cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [FRAME_BYTES*BITS_PER_BYTE-1:0] frame_data,
	input  logic [COUNT_W-1:0]            frame_bytes,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          signal_valid,
	output logic signed [VALUE_W-1:0]     physical_value
);

	localparam logic [COUNT_W-1:0] MAX_BYTES = COUNT_W'(FRAME_BYTES);

	logic [START_W-1:0]        start_bit_q;
	logic [LEN_W-1:0]          bit_length_q;
	logic                      byte_order_q;
	logic                      is_signed_q;
	logic signed [SCALE_W-1:0] scale_q;
	logic signed [VALUE_W-1:0] offset_q;
	logic signed [VALUE_W-1:0] lower_q;
	logic signed [VALUE_W-1:0] upper_q;

	logic advance;

	logic [DATA_W-1:0]  data_ext;
	logic [COUNT_W-1:0] nbytes;
	logic [LEN_W-1:0]   total_bits;
	logic [7:0]         end_bit;
	logic               fits;
	logic [DATA_W-1:0]  mask;
	logic [DATA_W-1:0]  seg_intel;
	logic [DATA_W-1:0]  seg_moto;
	logic [DATA_W-1:0]  raw_bits;
	logic [LEN_W-1:0]   moto_shift;
	logic [START_W-1:0] top_index;
	logic               neg;
	logic [DATA_W-1:0]  raw_ext;

	logic                     vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic                     ok_s1, ok_s2, ok_s3, ok_s4, ok_s5;
	logic signed [RAW_W-1:0]  raw_s1;
	logic signed [PROD_W-1:0] plo_s2;
	logic signed [PROD_W-1:0] phi_s2;
	logic signed [WIDE_W-1:0] sum_s3;
	logic signed [WIDE_W-1:0] sum_s4;
	logic signed [WIDE_W-1:0] sum_s5;

	logic                      out_valid_q;
	logic                      sig_ok_q;
	logic signed [VALUE_W-1:0] phys_q;

	logic signed [WIDE_W-1:0] lower_wide;
	logic signed [WIDE_W-1:0] upper_wide;
	logic signed [WIDE_W-1:0] offset_wide;

	assign advance  = !(out_valid_q && out_stall);
	assign in_stall = !advance;

	assign out_valid      = out_valid_q;
	assign signal_valid   = sig_ok_q;
	assign physical_value = phys_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_bit_q  <= START_RESET;
			bit_length_q <= LEN_RESET;
			byte_order_q <= BYTE_ORDER_INTEL;
			is_signed_q  <= 1'b0;
			scale_q      <= SCALE_RESET;
			offset_q     <= OFFSET_RESET;
			lower_q      <= LOWER_RESET;
			upper_q      <= UPPER_RESET;
		end else if (cfg_write_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_START_BIT:    start_bit_q  <= cfg_data[START_W-1:0];
				REG_BIT_LENGTH:   bit_length_q <= cfg_data[LEN_W-1:0];
				REG_BYTE_ORDER:   byte_order_q <= cfg_data[0];
				REG_IS_SIGNED:    is_signed_q  <= cfg_data[0];
				REG_SCALE_FACTOR: scale_q      <= cfg_data[SCALE_W-1:0];
				REG_OFFSET_VALUE: offset_q     <= cfg_data;
				REG_LOWER_LIMIT:  lower_q      <= cfg_data;
				REG_UPPER_LIMIT:  upper_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1 logic: frame length check and field extraction.
	always_comb begin
		data_ext   = DATA_W'(frame_data);
		nbytes     = (frame_bytes > MAX_BYTES) ? MAX_BYTES : frame_bytes;
		total_bits = {nbytes, 3'b000};
		end_bit    = 8'(start_bit_q) + 8'(bit_length_q);
		fits       = (bit_length_q != '0) && (bit_length_q <= LEN_W'(DATA_W))
			&& (end_bit <= 8'(total_bits));
		mask       = (DATA_W'(1) << bit_length_q) - DATA_W'(1);
		seg_intel  = (data_ext >> start_bit_q) & mask;
		seg_moto   = (mirror_bytes(data_ext) >> start_bit_q) & mask;
		moto_shift = LEN_W'(DATA_W) - bit_length_q;
		raw_bits   = (byte_order_q == BYTE_ORDER_MOTOROLA)
			? (reverse_word(seg_moto) >> moto_shift) : seg_intel;
		top_index  = START_W'(bit_length_q - LEN_W'(1));
		neg        = is_signed_q && raw_bits[top_index];
		raw_ext    = neg ? (raw_bits | ~mask) : raw_bits;
	end

	assign offset_wide = WIDE_W'(offset_q);
	assign lower_wide  = WIDE_W'(lower_q);
	assign upper_wide  = WIDE_W'(upper_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			vld_s1      <= in_valid;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			vld_s5      <= vld_s4;
			out_valid_q <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ok_s1  <= fits;
			raw_s1 <= {neg, raw_ext};

			ok_s2  <= ok_s1;
			plo_s2 <= $signed({1'b0, raw_s1[HALF_W-1:0]}) * scale_q;
			phi_s2 <= $signed(raw_s1[RAW_W-1:HALF_W]) * scale_q;

			ok_s3  <= ok_s2;
			sum_s3 <= (WIDE_W'(phi_s2) <<< HALF_W) + WIDE_W'(plo_s2);

			ok_s4  <= ok_s3;
			sum_s4 <= sum_s3 + offset_wide;

			ok_s5  <= ok_s4;
			sum_s5 <= (sum_s4 < lower_wide) ? lower_wide : sum_s4;

			sig_ok_q <= ok_s5;
			if (!ok_s5) begin
				phys_q <= '0;
			end else if (sum_s5 > upper_wide) begin
				phys_q <= upper_q;
			end else begin
				phys_q <= sum_s5[VALUE_W-1:0];
			end
		end
	end

endmodule
